### hw/rtl/wsl_pkg.sv
package wsl_pkg;

  localparam int DIV_NW = 48;
  localparam int DIV_DW = 40;
  localparam int SUM_W  = 40;
  localparam int IDX_W  = 6;
  localparam int ATAN_ENTRIES = 24;

  localparam logic signed [31:0] CORDIC_GAIN_Q30 = 32'sd652032874;
  localparam logic signed [63:0] W054_Q30        = 64'sd579820585;
  localparam logic signed [63:0] W046_Q30        = 64'sd493921239;
  localparam logic [46:0]        TWO_PI_Q28      = 47'd1686629713;

  typedef enum logic [4:0] {
    OP_NONE,
    OP_LOAD,
    OP_CMUL,
    OP_CROUND,
    OP_PHASE,
    OP_WPH_CAP,
    OP_CORD_W,
    OP_WMUL,
    OP_WCALC,
    OP_CORD_S,
    OP_SMUL,
    OP_HDIV,
    OP_HCAP,
    OP_WRITE,
    OP_NINIT,
    OP_READ,
    OP_NDIV,
    OP_ZERO,
    OP_QCAP,
    OP_INC
  } op_e;

  typedef enum logic [4:0] {
    S_IDLE,
    S_TAP,
    S_CROUND,
    S_WDIV,
    S_CORDW,
    S_CORDW_WAIT,
    S_WCALC,
    S_CORDS,
    S_CORDS_WAIT,
    S_HDIV,
    S_HDIV_WAIT,
    S_WRITE,
    S_NINIT,
    S_READ,
    S_NDIV,
    S_NDIV_WAIT,
    S_OUT
  } state_e;

  typedef struct packed {
    op_e op;
  } dp_cmd_t;

  typedef struct packed {
    logic center;
    logic last;
    logic err;
    logic div_done;
    logic cord_done;
    logic out_taken;
  } dp_stat_t;

  // atan(2^-j) in Q0.32 turns
  function automatic logic signed [31:0] atan_turn(input logic [4:0] j);
    logic signed [31:0] r;
    unique case (j)
      5'd0:  r = 32'h20000000;
      5'd1:  r = 32'h12E4051E;
      5'd2:  r = 32'h09FB385B;
      5'd3:  r = 32'h051111D4;
      5'd4:  r = 32'h028B0D43;
      5'd5:  r = 32'h0145D7E1;
      5'd6:  r = 32'h00A2F61E;
      5'd7:  r = 32'h00517C55;
      5'd8:  r = 32'h0028BE53;
      5'd9:  r = 32'h00145F2F;
      5'd10: r = 32'h000A2F98;
      5'd11: r = 32'h000517CC;
      5'd12: r = 32'h00028BE6;
      5'd13: r = 32'h000145F3;
      5'd14: r = 32'h0000A2FA;
      5'd15: r = 32'h0000517D;
      5'd16: r = 32'h000028BE;
      5'd17: r = 32'h0000145F;
      5'd18: r = 32'h00000A30;
      5'd19: r = 32'h00000518;
      5'd20: r = 32'h0000028C;
      5'd21: r = 32'h00000146;
      5'd22: r = 32'h000000A3;
      5'd23: r = 32'h00000051;
      default: r = 32'h0;
    endcase
    return r;
  endfunction

endpackage

### hw/rtl/wsl_ram.sv
module wsl_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 63
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

### hw/rtl/wsl_cordic.sv
module wsl_cordic #(
  parameter int CORDIC_STEPS = 16
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start_i,
  input  logic [31:0]        phase_i,
  output logic               done_o,
  output logic signed [31:0] cos_o,
  output logic signed [31:0] sin_o
);
  import wsl_pkg::*;

  localparam int NSTEP = (CORDIC_STEPS > ATAN_ENTRIES) ? ATAN_ENTRIES : CORDIC_STEPS;

  logic signed [33:0] x_q, x_d, y_q, y_d, dx, dy;
  logic signed [31:0] z_q, z_d, at;
  logic [1:0]         quad_q, quad_d;
  logic [4:0]         j_q, j_d;
  logic               busy_q, busy_d, done_q, done_d;

  always_comb begin
    x_d    = x_q;
    y_d    = y_q;
    z_d    = z_q;
    quad_d = quad_q;
    j_d    = j_q;
    busy_d = busy_q;
    done_d = 1'b0;
    at     = atan_turn(j_q);
    dx     = y_q >>> j_q;
    dy     = x_q >>> j_q;
    if (start_i) begin
      x_d    = 34'(CORDIC_GAIN_Q30);
      y_d    = '0;
      z_d    = {2'b00, phase_i[29:0]};
      quad_d = phase_i[31:30];
      j_d    = '0;
      busy_d = 1'b1;
    end else if (busy_q) begin
      if (z_q >= 0) begin
        x_d = x_q - dx;
        y_d = y_q + dy;
        z_d = z_q - at;
      end else begin
        x_d = x_q + dx;
        y_d = y_q - dy;
        z_d = z_q + at;
      end
      j_d = j_q + 5'd1;
      if (j_q == 5'(NSTEP - 1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      j_q    <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      j_q    <= j_d;
    end
  end

  always_ff @(posedge clk_i) begin
    x_q    <= x_d;
    y_q    <= y_d;
    z_q    <= z_d;
    quad_q <= quad_d;
  end

  always_comb begin
    unique case (quad_q)
      2'd0: begin
        cos_o = 32'(x_q);
        sin_o = 32'(y_q);
      end
      2'd1: begin
        cos_o = 32'(-y_q);
        sin_o = 32'(x_q);
      end
      2'd2: begin
        cos_o = 32'(-x_q);
        sin_o = 32'(-y_q);
      end
      default: begin
        cos_o = 32'(y_q);
        sin_o = 32'(-x_q);
      end
    endcase
  end

  assign done_o = done_q;

endmodule

### hw/rtl/wsl_div.sv
module wsl_div (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       start_i,
  input  logic [wsl_pkg::DIV_NW-1:0] num_i,
  input  logic [wsl_pkg::DIV_DW-1:0] den_i,
  output logic                       done_o,
  output logic [wsl_pkg::DIV_NW-1:0] quo_o
);
  import wsl_pkg::*;

  localparam int CW = $clog2(DIV_NW);

  logic [DIV_DW-1:0] rem_q, rem_d, den_q, den_d;
  logic [DIV_NW-1:0] quo_q, quo_d;
  logic [CW-1:0]     cnt_q, cnt_d;
  logic              busy_q, busy_d, done_q, done_d;
  logic [DIV_DW:0]   trial, diff;
  logic              ge;

  // restoring division, one quotient bit per cycle
  always_comb begin
    rem_d  = rem_q;
    den_d  = den_q;
    quo_d  = quo_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    done_d = 1'b0;
    trial  = {rem_q, quo_q[DIV_NW-1]};
    diff   = trial - {1'b0, den_q};
    ge     = trial >= {1'b0, den_q};
    if (start_i) begin
      rem_d  = '0;
      den_d  = den_i;
      quo_d  = num_i;
      cnt_d  = '0;
      busy_d = 1'b1;
    end else if (busy_q) begin
      rem_d = ge ? diff[DIV_DW-1:0] : trial[DIV_DW-1:0];
      quo_d = {quo_q[DIV_NW-2:0], ge};
      cnt_d = cnt_q + CW'(1);
      if (cnt_q == CW'(DIV_NW - 1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    den_q <= den_d;
    quo_q <= quo_d;
  end

  assign done_o = done_q;
  assign quo_o  = quo_q;

endmodule

### hw/rtl/wsl_datapath.sv
module wsl_datapath #(
  parameter int MAX_TAPS     = 63,
  parameter int CORDIC_STEPS = 16
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  wsl_pkg::dp_cmd_t    cmd_i,
  output wsl_pkg::dp_stat_t   stat_o,
  input  logic                tap_count_we_i,
  input  logic [5:0]          tap_count_i,
  input  logic [15:0]         cutoff_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output logic signed [15:0]  coefficient_o,
  output logic [5:0]          tap_index_o,
  output logic                last_tap_o,
  output logic                sum_error_o
);
  import wsl_pkg::*;

  localparam int AW    = $clog2(MAX_TAPS);
  localparam int MAXODD = (MAX_TAPS - 1) | 1;

  logic [5:0]         tap_count_q, len_q, idx_q, len_raw, len_lim, m, half;
  logic [15:0]        fc_q, fk;
  logic signed [6:0]  k_q, k_d;
  logic [6:0]         kmag;
  logic [31:0]        ph_q, wph_q;
  logic signed [31:0] w_q, h_q, a, raw, wc, ws;
  logic signed [63:0] prod_q;
  logic signed [SUM_W-1:0] sum_q;
  logic               err_q, neg_q, out_valid_q, last_q, serr_q, out_taken;
  logic [15:0]        coef_q;
  logic [5:0]         tidx_q;
  logic [32:0]        amag, rmag;
  logic [31:0]        hq;
  logic [DIV_NW-1:0]  div_num, quo;
  logic [DIV_DW-1:0]  div_den;
  logic               div_start, div_done, cord_start, cord_done;
  logic [31:0]        cord_phase;
  logic [15:0]        qsat;

  assign len_raw = tap_count_q | 6'd1;
  assign len_lim = (32'(len_raw) > MAXODD) ? 6'(MAXODD) : len_raw;
  assign m       = len_q - 6'd1;
  assign half    = m >> 1;
  assign k_d     = $signed({1'b0, idx_q}) - $signed({1'b0, half});
  assign fk      = fc_q * 16'(k_d);
  assign kmag    = k_q[6] ? 7'(-k_q) : 7'(k_q);
  assign a       = prod_q[63:32];
  assign amag    = a[31] ? (33'd0 - {a[31], a}) : {1'b0, a};

  // divider operand select
  always_comb begin
    div_start = 1'b0;
    div_num   = '0;
    div_den   = '0;
    unique case (cmd_i.op)
      OP_PHASE: begin
        div_start = 1'b1;
        div_num   = {10'b0, idx_q, 32'b0} + {42'b0, half};
        div_den   = {34'b0, m};
      end
      OP_HDIV: begin
        div_start = 1'b1;
        div_num   = {15'b0, amag};
        div_den   = {33'b0, kmag};
      end
      OP_NDIV: begin
        div_start = 1'b1;
        div_num   = {rmag, 15'b0} + {9'b0, sum_q[SUM_W-1:1]};
        div_den   = sum_q;
      end
      default: ;
    endcase
  end

  assign cord_start = (cmd_i.op == OP_CORD_W) || (cmd_i.op == OP_CORD_S);
  assign cord_phase = (cmd_i.op == OP_CORD_W) ? wph_q : ph_q;

  wsl_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .num_i   (div_num),
    .den_i   (div_den),
    .done_o  (div_done),
    .quo_o   (quo)
  );

  wsl_cordic #(
    .CORDIC_STEPS(CORDIC_STEPS)
  ) u_cordic (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (cord_start),
    .phase_i (cord_phase),
    .done_o  (cord_done),
    .cos_o   (wc),
    .sin_o   (ws)
  );

  wsl_ram #(
    .WIDTH(32),
    .DEPTH(MAX_TAPS)
  ) u_taps (
    .clk_i   (clk_i),
    .we_i    (cmd_i.op == OP_WRITE),
    .waddr_i (AW'(idx_q)),
    .wdata_i (h_q),
    .re_i    (cmd_i.op == OP_READ),
    .raddr_i (AW'(idx_q)),
    .rdata_o (raw)
  );

  assign rmag = raw[31] ? (33'd0 - {raw[31], raw}) : {1'b0, raw};
  assign hq   = quo[31:0];

  // round-half-away quotient magnitude to saturated Q1.15
  always_comb begin
    if (!neg_q) begin
      qsat = (quo > DIV_NW'(32767)) ? 16'h7FFF : quo[15:0];
    end else begin
      qsat = (quo > DIV_NW'(32768)) ? 16'h8000 : 16'(16'd0 - quo[15:0]);
    end
  end

  assign out_taken = out_valid_q && !out_stall_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tap_count_q <= 6'd31;
      len_q       <= 6'd1;
      idx_q       <= '0;
      err_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (tap_count_we_i) begin
        tap_count_q <= tap_count_i;
      end
      if (out_taken) begin
        out_valid_q <= 1'b0;
      end
      unique case (cmd_i.op)
        OP_LOAD: begin
          len_q <= len_lim;
          idx_q <= '0;
        end
        OP_WRITE, OP_INC: idx_q <= idx_q + 6'd1;
        OP_NINIT: begin
          idx_q <= '0;
          err_q <= (sum_q <= 0);
        end
        OP_ZERO, OP_QCAP: out_valid_q <= 1'b1;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    unique case (cmd_i.op)
      OP_LOAD: begin
        fc_q  <= cutoff_i;
        sum_q <= '0;
      end
      OP_CMUL:    prod_q <= $signed({17'b0, 47'(fc_q) * TWO_PI_Q28});
      OP_CROUND:  h_q <= 32'((prod_q + 64'sd32768) >>> 16);
      OP_PHASE: begin
        k_q  <= k_d;
        ph_q <= {fk, 16'b0};
      end
      OP_WPH_CAP: wph_q <= quo[31:0];
      OP_WMUL:    prod_q <= 64'(wc) * W046_Q30;
      OP_WCALC:   w_q <= 32'(W054_Q30 - (prod_q >>> 30));
      OP_SMUL:    prod_q <= 64'(ws) * 64'(w_q);
      OP_HDIV:    neg_q <= a[31] ^ k_q[6];
      OP_HCAP:    h_q <= neg_q ? 32'(32'd0 - hq) : hq;
      OP_WRITE:   sum_q <= sum_q + SUM_W'(h_q);
      OP_NDIV:    neg_q <= raw[31];
      OP_ZERO: begin
        coef_q <= '0;
        tidx_q <= idx_q;
        last_q <= stat_o.last;
        serr_q <= err_q;
      end
      OP_QCAP: begin
        coef_q <= qsat;
        tidx_q <= idx_q;
        last_q <= stat_o.last;
        serr_q <= err_q;
      end
      default: ;
    endcase
  end

  assign stat_o.center    = (idx_q == half);
  assign stat_o.last      = (idx_q == m);
  assign stat_o.err       = err_q;
  assign stat_o.div_done  = div_done;
  assign stat_o.cord_done = cord_done;
  assign stat_o.out_taken = out_taken;

  assign out_valid_o   = out_valid_q;
  assign coefficient_o = $signed(coef_q);
  assign tap_index_o   = tidx_q;
  assign last_tap_o    = last_q;
  assign sum_error_o   = serr_q;

endmodule

### hw/rtl/wsl_ctrl.sv
module wsl_ctrl (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  wsl_pkg::dp_stat_t  stat_i,
  output wsl_pkg::dp_cmd_t   cmd_o
);
  import wsl_pkg::*;

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d   = state_q;
    cmd_o.op  = OP_NONE;
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.op = OP_LOAD;
          state_d  = S_TAP;
        end
      end
      S_TAP: begin
        if (stat_i.center) begin
          cmd_o.op = OP_CMUL;
          state_d  = S_CROUND;
        end else begin
          cmd_o.op = OP_PHASE;
          state_d  = S_WDIV;
        end
      end
      S_CROUND: begin
        cmd_o.op = OP_CROUND;
        state_d  = S_WRITE;
      end
      S_WDIV: begin
        if (stat_i.div_done) begin
          cmd_o.op = OP_WPH_CAP;
          state_d  = S_CORDW;
        end
      end
      S_CORDW: begin
        cmd_o.op = OP_CORD_W;
        state_d  = S_CORDW_WAIT;
      end
      S_CORDW_WAIT: begin
        if (stat_i.cord_done) begin
          cmd_o.op = OP_WMUL;
          state_d  = S_WCALC;
        end
      end
      S_WCALC: begin
        cmd_o.op = OP_WCALC;
        state_d  = S_CORDS;
      end
      S_CORDS: begin
        cmd_o.op = OP_CORD_S;
        state_d  = S_CORDS_WAIT;
      end
      S_CORDS_WAIT: begin
        if (stat_i.cord_done) begin
          cmd_o.op = OP_SMUL;
          state_d  = S_HDIV;
        end
      end
      S_HDIV: begin
        cmd_o.op = OP_HDIV;
        state_d  = S_HDIV_WAIT;
      end
      S_HDIV_WAIT: begin
        if (stat_i.div_done) begin
          cmd_o.op = OP_HCAP;
          state_d  = S_WRITE;
        end
      end
      S_WRITE: begin
        cmd_o.op = OP_WRITE;
        state_d  = stat_i.last ? S_NINIT : S_TAP;
      end
      S_NINIT: begin
        cmd_o.op = OP_NINIT;
        state_d  = S_READ;
      end
      S_READ: begin
        cmd_o.op = OP_READ;
        state_d  = S_NDIV;
      end
      S_NDIV: begin
        if (stat_i.err) begin
          cmd_o.op = OP_ZERO;
          state_d  = S_OUT;
        end else begin
          cmd_o.op = OP_NDIV;
          state_d  = S_NDIV_WAIT;
        end
      end
      S_NDIV_WAIT: begin
        if (stat_i.div_done) begin
          cmd_o.op = OP_QCAP;
          state_d  = S_OUT;
        end
      end
      S_OUT: begin
        if (stat_i.out_taken) begin
          if (stat_i.last) begin
            state_d = S_IDLE;
          end else begin
            cmd_o.op = OP_INC;
            state_d  = S_READ;
          end
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  assign in_stall_o = (state_q != S_IDLE);

endmodule

### hw/rtl/windowed_sinc_lowpass_design.sv
// Channel   Direction  Handshake                    Payload
// cutoff    in         in_valid_i / in_stall_o      cutoff_i
// taps      out        out_valid_o / out_stall_i    coefficient_o, tap_index_o,
//                                                   last_tap_o, sum_error_o
// config    in         tap_count_we_i               tap_count_i
//
// One request at a time; its run time for L taps is set by the shared
// one-bit-per-cycle 48-bit divider (window phase, sinc/k, normalization) and
// the shared iterative CORDIC with CORDIC_STEPS capped at 24, plus output stalls.
// in_stall_o is high from acceptance until the last tap transaction completes.
// Reset (rst_ni low, async) returns to idle with tap_count = 31.
module windowed_sinc_lowpass_design #(
  parameter int MAX_TAPS     = 63,
  parameter int CORDIC_STEPS = 16
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               tap_count_we_i,
  input  logic [5:0]         tap_count_i,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic [15:0]        cutoff_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic signed [15:0] coefficient_o,
  output logic [5:0]         tap_index_o,
  output logic               last_tap_o,
  output logic               sum_error_o
);
  import wsl_pkg::*;

  dp_cmd_t  cmd;
  dp_stat_t stat;

  wsl_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .stat_i     (stat),
    .cmd_o      (cmd)
  );

  wsl_datapath #(
    .MAX_TAPS    (MAX_TAPS),
    .CORDIC_STEPS(CORDIC_STEPS)
  ) u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (cmd),
    .stat_o         (stat),
    .tap_count_we_i (tap_count_we_i),
    .tap_count_i    (tap_count_i),
    .cutoff_i       (cutoff_i),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .coefficient_o  (coefficient_o),
    .tap_index_o    (tap_index_o),
    .last_tap_o     (last_tap_o),
    .sum_error_o    (sum_error_o)
  );

endmodule

### tb/sv/windowed_sinc_lowpass_design_tb.sv
`timescale 1ns / 100ps

module windowed_sinc_lowpass_design_tb;

  localparam int MAX_TAPS     = 63;
  localparam int CORDIC_STEPS = 16;
  localparam int STALL_LIMIT  = 200000;

  typedef struct packed {
    logic signed [15:0] coefficient;
    logic [5:0]         tap_index;
    logic               last_tap;
    logic               sum_error;
  } tap_t;

  logic               clk_i;
  logic               rst_ni;
  logic               tap_count_we_i;
  logic [5:0]         tap_count_i;
  logic               in_valid_i;
  logic               in_stall_o;
  logic [15:0]        cutoff_i;
  logic               out_valid_o;
  logic               out_stall_i;
  logic signed [15:0] coefficient_o;
  logic [5:0]         tap_index_o;
  logic               last_tap_o;
  logic               sum_error_o;

  windowed_sinc_lowpass_design #(
    .MAX_TAPS     (MAX_TAPS),
    .CORDIC_STEPS (CORDIC_STEPS)
  ) u_top (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .tap_count_we_i (tap_count_we_i),
    .tap_count_i    (tap_count_i),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .cutoff_i       (cutoff_i),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .coefficient_o  (coefficient_o),
    .tap_index_o    (tap_index_o),
    .last_tap_o     (last_tap_o),
    .sum_error_o    (sum_error_o)
  );

  logic [15:0] cutoff_q[$];
  tap_t        taps_due[$];
  logic [5:0]  model_tap_count;
  int          errors = 0;
  int          idle_cycles = 0;
  bit          no_idle;

  initial clk_i = 1'b0;
  always #5 clk_i = ~clk_i;

  function automatic longint floor_shr(input longint v, input int s);
    return v >>> s;
  endfunction

  function automatic longint atan_q32(input int j);
    return longint'(wsl_pkg::atan_turn(5'(j)));
  endfunction

  // cos/sin in Q2.30 from a Q0.32 phase
  task automatic rotate(input logic [31:0] ph, output longint cs, output longint sn);
    longint x, y, z, dx, dy;
    int     steps;
    x = 652032874;
    y = 0;
    z = longint'(ph[29:0]);
    steps = (CORDIC_STEPS > 24) ? 24 : CORDIC_STEPS;
    for (int j = 0; j < steps; j++) begin
      dx = floor_shr(y, j);
      dy = floor_shr(x, j);
      if (z >= 0) begin
        x -= dx; y += dy; z -= atan_q32(j);
      end else begin
        x += dx; y -= dy; z += atan_q32(j);
      end
    end
    case (ph[31:30])
      2'd0: begin cs = x;  sn = y;  end
      2'd1: begin cs = -y; sn = x;  end
      2'd2: begin cs = -x; sn = -y; end
      default: begin cs = y; sn = -x; end
    endcase
  endtask

  task automatic design_filter(input logic [15:0] fc);
    longint     h[MAX_TAPS];
    longint     len, m, half, sum, k, c, s, wc, ws, w, num, q;
    logic [31:0] ph, wph;
    bit         bad;
    tap_t       t;
    len = longint'(model_tap_count | 6'd1);
    if (len > ((MAX_TAPS - 1) | 1)) len = (MAX_TAPS - 1) | 1;
    m = len - 1;
    half = m / 2;
    sum = 0;
    for (longint i = 0; i < len; i++) begin
      if (i == half) begin
        h[i] = (longint'(fc) * 1686629713 + 32768) >>> 16;
      end else begin
        k = i - half;
        ph = (32'(fc) * 32'(k)) << 16;
        wph = 32'(((i << 32) + m / 2) / m);
        rotate(ph, c, s);
        rotate(wph, wc, ws);
        w = 579820585 - floor_shr(wc * 493921239, 30);
        h[i] = floor_shr(s * w, 32) / k;
      end
      h[i] = longint'(int'(h[i]));
      sum += h[i];
    end
    bad = (sum <= 0);
    for (longint i = 0; i < len; i++) begin
      q = 0;
      if (!bad) begin
        num = h[i] * 32768;
        if (num >= 0) q = (num + sum / 2) / sum;
        else q = -((-num + sum / 2) / sum);
        if (q > 32767) q = 32767;
        if (q < -32768) q = -32768;
      end
      t.coefficient = 16'(q);
      t.tap_index   = 6'(i);
      t.last_tap    = (i == len - 1);
      t.sum_error   = bad;
      taps_due.push_back(t);
    end
  endtask

  // driver
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
      cutoff_i   <= '0;
    end else if (in_valid_i && !in_stall_o) begin
      design_filter(cutoff_i);
      if (cutoff_q.size() > 0 && (no_idle || $urandom_range(99) >= 29)) begin
        cutoff_i   <= cutoff_q.pop_front();
        in_valid_i <= 1'b1;
      end else begin
        in_valid_i <= 1'b0;
      end
    end else if (!in_valid_i && cutoff_q.size() > 0 &&
                 (no_idle || $urandom_range(99) >= 29)) begin
      cutoff_i   <= cutoff_q.pop_front();
      in_valid_i <= 1'b1;
    end
  end

  // monitor
  always @(posedge clk_i or negedge rst_ni) begin
    tap_t exp_t;
    if (!rst_ni) begin
      out_stall_i <= 1'b0;
    end else begin
      if (out_valid_o && !out_stall_i) begin
        if (taps_due.size() == 0) begin
          $display("%0t: unexpected tap idx=%0d coef=%0d", $time, tap_index_o,
                   coefficient_o);
          errors++;
        end else begin
          exp_t = taps_due.pop_front();
          if (exp_t !== {coefficient_o, tap_index_o, last_tap_o, sum_error_o}) begin
            $display("%0t: mismatch coef/idx/last/err exp %0d/%0d/%0b/%0b act %0d/%0d/%0b/%0b",
                     $time, exp_t.coefficient, exp_t.tap_index, exp_t.last_tap,
                     exp_t.sum_error, coefficient_o, tap_index_o, last_tap_o,
                     sum_error_o);
            errors++;
          end
        end
      end
      out_stall_i <= no_idle ? 1'b0 : ($urandom_range(99) < 29);
    end
  end

  // watchdog
  always @(posedge clk_i) begin
    if (!rst_ni || (in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= STALL_LIMIT) begin
      $display("** windowed_sinc_lowpass_design: FAILED **");
      $finish;
    end
  end

  task automatic wait_drained();
    while (cutoff_q.size() > 0 || in_valid_i || taps_due.size() > 0)
      @(posedge clk_i);
    repeat (20) @(posedge clk_i);
  endtask

  task automatic write_tap_count(input logic [5:0] v);
    tap_count_i    <= v;
    tap_count_we_i <= 1'b1;
    @(posedge clk_i);
    tap_count_we_i <= 1'b0;
    model_tap_count = v;
  endtask

  task automatic random_cutoffs(input int n);
    repeat (n) begin
      case ($urandom_range(9))
        0:       cutoff_q.push_back(16'($urandom));
        1:       cutoff_q.push_back(16'($urandom_range(32768, 65535)));
        default: cutoff_q.push_back(16'($urandom_range(1, 32768)));
      endcase
    end
  endtask

  initial begin
    logic [5:0] settings[$];
    no_idle = 1'b0;
    model_tap_count = 6'd31;
    rst_ni = 1'b0;
    tap_count_we_i = 1'b0;
    tap_count_i = '0;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // reset default count, directed cutoffs
    cutoff_q.push_back(16'd0);
    cutoff_q.push_back(16'd1);
    cutoff_q.push_back(16'd32768);
    cutoff_q.push_back(16'd16384);
    cutoff_q.push_back(16'd65535);
    cutoff_q.push_back(16'hAAAA);
    cutoff_q.push_back(16'h5555);
    wait_drained();

    // single tap, even counts, zero count, full width, max
    settings = '{6'd1, 6'd0, 6'd4, 6'd63, 6'd62, 6'd3};
    foreach (settings[i]) begin
      write_tap_count(settings[i]);
      cutoff_q.push_back(16'd0);
      cutoff_q.push_back(16'd12000);
      cutoff_q.push_back(16'($urandom_range(1, 32768)));
      wait_drained();
    end

    // random phases
    for (int p = 0; p < 8; p++) begin
      write_tap_count(p == 0 ? 6'd9 : 6'($urandom_range(0, 15)));
      no_idle = (p == 3);
      random_cutoffs(14);
      wait_drained();
    end
    write_tap_count(6'($urandom_range(0, 63)));
    random_cutoffs(6);
    wait_drained();

    if (errors == 0) begin
      $display("** windowed_sinc_lowpass_design: PASSED **");
    end else begin
      $display("** windowed_sinc_lowpass_design: FAILED **");
    end
    $finish;
  end

endmodule
